FILE: rtl/cde_pkg.sv
// Shared constants, codes and types of the circular deque engine.
package cde_pkg;

   localparam int DEPTH  = 8;
   localparam int WORD_W = 32;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_REAR  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_REAR   = 3'd3;
   localparam logic [2:0] OP_LIST       = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [WORD_W-1:0] value;
      logic                     last;
   } rsp_type;

endpackage

FILE: rtl/cde_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module cde_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/cde_ctrl.sv
// Sequencer of the deque: pointers, element count and store accesses.
module cde_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [2:0]                        req_opcode,
   input  logic signed [cde_pkg::WORD_W-1:0] req_value,
   input  logic                              out_free,
   output logic                              res_valid,
   output cde_pkg::rsp_type                  res,
   output logic                              wr_en,
   output logic [cde_pkg::IDX_W-1:0]         wr_addr,
   output logic [cde_pkg::WORD_W-1:0]        wr_data,
   output logic                              rd_en,
   output logic [cde_pkg::IDX_W-1:0]         rd_addr,
   input  logic [cde_pkg::WORD_W-1:0]        rd_data
);

   localparam int IDX_W = cde_pkg::IDX_W;
   localparam int CNT_W = cde_pkg::CNT_W;
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(cde_pkg::DEPTH);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(cde_pkg::DEPTH - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_POP,
      S_LIST
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] front_ff, front_in;
   logic [IDX_W-1:0] rear_ff, rear_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] left_ff, left_in;
   logic [IDX_W-1:0] list_idx_ff, list_idx_in;

   function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
      return (idx == IDX_LAST) ? '0 : idx + IDX_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] idx);
      return (idx == '0) ? IDX_LAST : idx - IDX_W'(1);
   endfunction

   always_comb begin
      state_in    = state_ff;
      front_in    = front_ff;
      rear_in     = rear_ff;
      count_in    = count_ff;
      left_in     = left_ff;
      list_idx_in = list_idx_ff;
      wr_en       = 1'b0;
      wr_addr     = front_ff;
      wr_data     = req_value;
      rd_en       = 1'b0;
      rd_addr     = front_ff;
      res_valid   = 1'b0;
      res.status  = cde_pkg::ST_OK;
      res.value   = '0;
      res.last    = 1'b1;
      req_ready   = (state_ff == S_IDLE) && out_free;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               unique case (req_opcode) inside
                  cde_pkg::OP_PUSH_FRONT, cde_pkg::OP_PUSH_REAR: begin
                     res_valid = 1'b1;
                     if (count_ff == CNT_FULL) begin
                        res.status = cde_pkg::ST_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CNT_ONE;
                        if (count_ff == '0) begin
                           // The first word always lands in entry zero.
                           wr_addr  = '0;
                           front_in = '0;
                           rear_in  = '0;
                        end else if (req_opcode == cde_pkg::OP_PUSH_FRONT) begin
                           wr_addr  = idx_dec(front_ff);
                           front_in = idx_dec(front_ff);
                        end else begin
                           wr_addr = idx_inc(rear_ff);
                           rear_in = idx_inc(rear_ff);
                        end
                     end
                  end
                  cde_pkg::OP_POP_FRONT, cde_pkg::OP_POP_REAR: begin
                     if (count_ff == '0) begin
                        res_valid  = 1'b1;
                        res.status = cde_pkg::ST_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        count_in = count_ff - CNT_ONE;
                        state_in = S_POP;
                        if (req_opcode == cde_pkg::OP_POP_FRONT) begin
                           rd_addr  = front_ff;
                           front_in = idx_inc(front_ff);
                        end else begin
                           rd_addr = rear_ff;
                           rear_in = idx_dec(rear_ff);
                        end
                        if (count_ff == CNT_ONE) begin
                           front_in = '0;
                           rear_in  = '0;
                        end
                     end
                  end
                  cde_pkg::OP_LIST: begin
                     if (count_ff == '0) begin
                        res_valid  = 1'b1;
                        res.status = cde_pkg::ST_EMPTY;
                     end else begin
                        rd_en       = 1'b1;
                        rd_addr     = front_ff;
                        list_idx_in = idx_inc(front_ff);
                        left_in     = count_ff;
                        state_in    = S_LIST;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_POP: begin
            if (out_free) begin
               res_valid = 1'b1;
               res.value = $signed(rd_data);
               state_in  = S_IDLE;
            end
         end
         S_LIST: begin
            if (out_free) begin
               res_valid = 1'b1;
               res.value = $signed(rd_data);
               res.last  = (left_ff == CNT_ONE);
               if (left_ff == CNT_ONE) begin
                  state_in = S_IDLE;
               end else begin
                  // Fetch the next word while this one is handed on.
                  rd_en       = 1'b1;
                  rd_addr     = list_idx_ff;
                  list_idx_in = idx_inc(list_idx_ff);
                  left_in     = left_ff - CNT_ONE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         front_ff    <= '0;
         rear_ff     <= '0;
         count_ff    <= '0;
         left_ff     <= '0;
         list_idx_ff <= '0;
      end else begin
         state_ff    <= state_in;
         front_ff    <= front_in;
         rear_ff     <= rear_in;
         count_ff    <= count_in;
         left_ff     <= left_in;
         list_idx_ff <= list_idx_in;
      end
   end

endmodule

FILE: rtl/circular_deque_engine_top.sv
// Top level of the circular deque engine: sequencer, store and output register.
//
//   channel  direction  tdata               tuser        tlast
//   req      in         data_value [31:0]   opcode [2:0] -
//   rsp      out        result_value [31:0] status [1:0] last of the item
//
// A push is answered when taken; a pop reads the store, then sends the word;
// a list reads the stored words in turn through the single store read port.
// Reset is synchronous and empties the deque; store contents are not cleared.
// A stalled rsp side holds its word in the output register; the next request
// is taken once the previous item is done and that register can move.
module circular_deque_engine_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] data_value
   input  logic [2:0]  req_tuser,   // [2:0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] result_value
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast
);

   logic                              out_free;
   logic                              res_valid;
   cde_pkg::rsp_type                  res;
   logic                              wr_en;
   logic [cde_pkg::IDX_W-1:0]         wr_addr;
   logic [cde_pkg::WORD_W-1:0]        wr_data;
   logic                              rd_en;
   logic [cde_pkg::IDX_W-1:0]         rd_addr;
   logic [cde_pkg::WORD_W-1:0]        rd_data;
   logic                              rsp_valid_ff;
   cde_pkg::rsp_type                  rsp_ff;

   assign out_free = !rsp_valid_ff || rsp_tready;

   cde_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_opcode (req_tuser),
      .req_value  ($signed(req_tdata)),
      .out_free   (out_free),
      .res_valid  (res_valid),
      .res        (res),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

   cde_ram #(
      .WIDTH (cde_pkg::WORD_W),
      .DEPTH (cde_pkg::DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.value;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tlast  = rsp_ff.last;

endmodule

FILE: rtl/cde_checker.sv
// Port-level checks of the circular deque engine and their binding.
module cde_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // A result word that is not taken stays as it is.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result word changed");

   // A refused operation gives a single word with a zero value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != cde_pkg::ST_OK |-> rsp_tlast && rsp_tdata == '0)
      else $error("refused operation word malformed");

   // No request is taken while a listing is still being streamed out.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request taken in the middle of a listing");

   // Reset leaves no result word pending.
   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word present after reset");

   // Only known status codes reach the port.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser == cde_pkg::ST_OK || rsp_tuser == cde_pkg::ST_FULL
         || rsp_tuser == cde_pkg::ST_EMPTY)
      else $error("unknown status code");

endmodule

bind circular_deque_engine_top cde_checker u_cde_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
